### rtl/core/hacd_pkg.sv
// Shared types, colors and dot-color function for the hires artifact color decoder.
// Depends on nothing; every module of the decoder imports it.
package hacd_pkg;

    // Configuration register indexes
    localparam logic [0:0] CFG_COLOR_ENABLE = 1'b0;
    localparam logic [0:0] CFG_MONO_PALETTE = 1'b1;

    // Monochrome palette codes
    localparam logic [1:0] MONO_WHITE = 2'd0;
    localparam logic [1:0] MONO_GREEN = 2'd1;
    localparam logic [1:0] MONO_AMBER = 2'd2;

    // Colors packed as blue, green, red
    localparam logic [23:0] RGB_BLACK  = 24'h000000;
    localparam logic [23:0] RGB_WHITE  = 24'hffffff;
    localparam logic [23:0] RGB_PURPLE = 24'hfd44ff;
    localparam logic [23:0] RGB_GREEN  = 24'h3cf514;
    localparam logic [23:0] RGB_BLUE   = 24'hfdcf14;
    localparam logic [23:0] RGB_ORANGE = 24'h3c6aff;
    localparam logic [23:0] RGB_AMBER  = 24'h14cffd;
    localparam logic [23:0] DIM_MASK   = 24'hc0c0c0;

    // Each byte gives seven dots, each shown twice
    localparam int DOTS_PER_BYTE = 14;
    localparam int DOT_CNT_W     = 4;
    localparam logic [DOT_CNT_W-1:0] LAST_DOT = DOT_CNT_W'(DOTS_PER_BYTE - 1);

    // One released byte: dot window, column parity, palette bit, end of line
    typedef struct packed {
        logic [10:0] run;
        logic        odd;
        logic        pal;
        logic        last;
    } hacd_job_t;

    // Live configuration seen by the dot generator
    typedef struct packed {
        logic       color_enable;
        logic [1:0] mono_palette;
    } hacd_cfg_t;

    // Artifact hue from {palette bit, column parity, dot parity}
    function automatic logic [23:0] artifact_rgb(input logic [2:0] code);
        logic [23:0] rgb;
        begin
            case (code)
                3'd0:    rgb = RGB_PURPLE;
                3'd1:    rgb = RGB_GREEN;
                3'd2:    rgb = RGB_GREEN;
                3'd3:    rgb = RGB_PURPLE;
                3'd4:    rgb = RGB_BLUE;
                3'd5:    rgb = RGB_ORANGE;
                3'd6:    rgb = RGB_ORANGE;
                3'd7:    rgb = RGB_BLUE;
                default: rgb = RGB_BLACK;
            endcase
            return rgb;
        end
    endfunction

    // Color of dot i (0..6) of a released byte
    function automatic logic [23:0] dot_rgb(input hacd_job_t job, input logic [2:0] i,
                                            input hacd_cfg_t cfg);
        logic        left;
        logic        dot;
        logic        right;
        logic [23:0] rgb;
        begin
            left  = job.run[{1'b0, i} + 4'd1];
            dot   = job.run[{1'b0, i} + 4'd2];
            right = job.run[{1'b0, i} + 4'd3];
            rgb   = RGB_BLACK;
            if (cfg.color_enable) begin
                if (dot) begin
                    if (left || right)
                        rgb = RGB_WHITE;
                    else
                        rgb = artifact_rgb({job.pal, job.odd, i[0]});
                end
                else if (left && right) begin
                    rgb = artifact_rgb({job.pal, job.odd, ~i[0]});
                end
            end
            else if (dot) begin
                case (cfg.mono_palette)
                    MONO_WHITE: rgb = RGB_WHITE;
                    MONO_GREEN: rgb = RGB_GREEN;
                    MONO_AMBER: rgb = RGB_AMBER;
                    default:    rgb = RGB_WHITE;
                endcase
            end
            return rgb;
        end
    endfunction

endpackage

### rtl/core/hacd_front.sv
// Front end: accepts screen bytes, tracks line position and issues one job per released byte.
// Depends on hacd_pkg.
module hacd_front #(
    parameter int BYTES_PER_LINE = 40
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [7:0]        video_byte,
    input  logic              line_start,
    input  logic              q_full,
    output logic              push,
    output hacd_pkg::hacd_job_t push_job
);
    import hacd_pkg::*;

    localparam int COL_W = $clog2(BYTES_PER_LINE + 1);
    localparam logic [COL_W-1:0] LAST_COL = COL_W'(BYTES_PER_LINE - 1);

    logic [7:0]       older_reg, older_next;
    logic [7:0]       pend_reg, pend_next;
    logic [COL_W-1:0] col_reg, col_next;
    logic             have_reg, have_next;
    logic             accept;
    logic             last_col;

    // Hold input while the queue is full
    assign in_stall = q_full;
    assign accept   = in_valid && !in_stall;
    assign last_col = (col_reg >= LAST_COL);
    assign push     = accept && !line_start && have_reg;

    // Build the job for the pending byte
    always_comb
    begin
        push_job.run  = {video_byte[1:0], pend_reg[6:0], older_reg[6:5]};
        push_job.odd  = col_reg[0];
        push_job.pal  = pend_reg[7];
        push_job.last = last_col;
    end

    // Advance line state
    always_comb
    begin
        older_next = older_reg;
        pend_next  = pend_reg;
        col_next   = col_reg;
        have_next  = have_reg;
        if (accept) begin
            if (line_start || !have_reg) begin
                older_next = 8'h00;
                pend_next  = video_byte;
                col_next   = '0;
                have_next  = 1'b1;
            end
            else if (last_col) begin
                older_next = 8'h00;
                pend_next  = 8'h00;
                col_next   = '0;
                have_next  = 1'b0;
            end
            else begin
                older_next = pend_reg;
                pend_next  = video_byte;
                col_next   = col_reg + COL_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            older_reg <= 8'h00;
            pend_reg  <= 8'h00;
            col_reg   <= '0;
            have_reg  <= 1'b0;
        end
        else begin
            older_reg <= older_next;
            pend_reg  <= pend_next;
            col_reg   <= col_next;
            have_reg  <= have_next;
        end
    end

endmodule

### rtl/core/hacd_queue.sv
// Two-entry job queue between the front end and the dot generator.
// Depends on hacd_pkg.
module hacd_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  hacd_pkg::hacd_job_t push_job,
    input  logic                pop,
    output logic                q_valid,
    output logic                q_full,
    output hacd_pkg::hacd_job_t head_job
);
    import hacd_pkg::*;

    hacd_job_t  entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    assign q_valid  = (count_reg != 2'd0);
    assign q_full   = (count_reg == 2'd2);
    assign head_job = entry_reg[rd_ptr_reg];

    // Advance pointers and occupancy
    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the word
    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_job;
    end

endmodule

### rtl/core/hacd_back.sv
// Back end: walks the fourteen dots of the head job, one per cycle unless the output stalls, into the output register.
// Depends on hacd_pkg.
module hacd_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_valid,
    input  hacd_pkg::hacd_job_t head_job,
    input  hacd_pkg::hacd_cfg_t cfg,
    output logic                pop,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [23:0]         pixel_rgb,
    output logic [23:0]         dimmed_rgb,
    output logic                last_of_byte,
    output logic                line_done
);
    import hacd_pkg::*;

    logic [DOT_CNT_W-1:0] dot_cnt_reg, dot_cnt_next;
    logic                 valid_reg, valid_next;
    logic [23:0]          pixel_reg;
    logic [23:0]          dimmed_reg;
    logic                 last_reg;
    logic                 done_reg;
    logic                 slot_free;
    logic                 fire;
    logic                 final_dot;
    logic [23:0]          rgb;

    assign slot_free = !valid_reg || !out_stall;
    assign fire      = q_valid && slot_free;
    assign final_dot = (dot_cnt_reg == LAST_DOT);
    assign pop       = fire && final_dot;
    assign rgb       = dot_rgb(head_job, dot_cnt_reg[DOT_CNT_W-1:1], cfg);

    // Step the dot counter and output valid
    always_comb
    begin
        dot_cnt_next = dot_cnt_reg;
        if (fire)
            dot_cnt_next = final_dot ? '0 : dot_cnt_reg + DOT_CNT_W'(1);
        valid_next = fire ? 1'b1 : (slot_free ? 1'b0 : valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            dot_cnt_reg <= '0;
            valid_reg   <= 1'b0;
        end
        else begin
            dot_cnt_reg <= dot_cnt_next;
            valid_reg   <= valid_next;
        end
    end

    // Load the output word
    always_ff @(posedge clk)
    begin
        if (fire) begin
            pixel_reg  <= rgb;
            dimmed_reg <= rgb & DIM_MASK;
            last_reg   <= final_dot;
            done_reg   <= final_dot && head_job.last;
        end
    end

    assign out_valid    = valid_reg;
    assign pixel_rgb    = pixel_reg;
    assign dimmed_rgb   = dimmed_reg;
    assign last_of_byte = last_reg;
    assign line_done    = done_reg;

endmodule

### rtl/core/hires_artifact_color_decoder.sv
// Hires artifact color decoder: one byte in, fourteen dot words out per released byte.
// Path: a released byte's job is queued, then each dot is registered at the outputs.
// Throughput: one dot per cycle from the dot generator while the output is not stalled;
// a two-word job queue lets the input side run ahead by up to two bytes.
// Reset: clears line state, queue and output valid; color decoding on, white palette.
// Depends on hacd_pkg, hacd_front, hacd_queue and hacd_back.
module hires_artifact_color_decoder #(
    parameter int BYTES_PER_LINE = 40
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  video_byte,
    input  logic        line_start,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [23:0] pixel_rgb,
    output logic [23:0] dimmed_rgb,
    output logic        last_of_byte,
    output logic        line_done,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [0:0]  cfg_index,
    input  logic [1:0]  cfg_data
);
    import hacd_pkg::*;

    logic       color_enable_reg, color_enable_next;
    logic [1:0] mono_palette_reg, mono_palette_next;
    hacd_cfg_t  cfg;
    hacd_job_t  push_job;
    hacd_job_t  head_job;
    logic       push;
    logic       pop;
    logic       q_valid;
    logic       q_full;

    // Configuration registers
    assign cfg_ready = 1'b1;

    always_comb
    begin
        color_enable_next = color_enable_reg;
        mono_palette_next = mono_palette_reg;
        if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_COLOR_ENABLE: color_enable_next = cfg_data[0];
                CFG_MONO_PALETTE: mono_palette_next = cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            color_enable_reg <= 1'b1;
            mono_palette_reg <= MONO_WHITE;
        end
        else begin
            color_enable_reg <= color_enable_next;
            mono_palette_reg <= mono_palette_next;
        end
    end

    assign cfg.color_enable = color_enable_reg;
    assign cfg.mono_palette = mono_palette_reg;

    hacd_front #(
        .BYTES_PER_LINE(BYTES_PER_LINE)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .video_byte (video_byte),
        .line_start (line_start),
        .q_full     (q_full),
        .push       (push),
        .push_job   (push_job)
    );

    hacd_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .q_valid  (q_valid),
        .q_full   (q_full),
        .head_job (head_job)
    );

    hacd_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (q_valid),
        .head_job     (head_job),
        .cfg          (cfg),
        .pop          (pop),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .pixel_rgb    (pixel_rgb),
        .dimmed_rgb   (dimmed_rgb),
        .last_of_byte (last_of_byte),
        .line_done    (line_done)
    );

`ifndef SYNTHESIS
    // End of line only on the final dot of a byte
    a_done_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && line_done |-> last_of_byte)
        else $error("line_done without last_of_byte");

    // Dimmed word always tracks the shown color
    a_dim_match: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (dimmed_rgb == (pixel_rgb & DIM_MASK)))
        else $error("dimmed_rgb does not match pixel_rgb");

    // No push into a full queue
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_full |-> !push)
        else $error("job pushed into full queue");

    // A job leaves only when one is queued
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> q_valid)
        else $error("job popped from empty queue");
`endif

endmodule
